>>> sv/fsms_pkg.sv
// Shared types and constants for the failsafe mode supervisor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fsms_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL    = 3'd0,
    MODE_WARNING   = 3'd1,
    MODE_RTH       = 3'd2,
    MODE_LAND      = 3'd3,
    MODE_EMERGENCY = 3'd4
  } mode_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_BATT_WARN   = 3'd0;
  localparam cfg_idx_t CFG_BATT_CRIT   = 3'd1;
  localparam cfg_idx_t CFG_ALT_LIMIT   = 3'd2;
  localparam cfg_idx_t CFG_FENCE_RAD   = 3'd3;
  localparam cfg_idx_t CFG_HOME_RAD    = 3'd4;
  localparam cfg_idx_t CFG_LANDED_ALT  = 3'd5;
  localparam cfg_idx_t CFG_RC_TIMEOUT  = 3'd6;
  localparam cfg_idx_t CFG_DEBOUNCE    = 3'd7;

  // Everything the result register carries besides the mode.
  typedef struct packed {
    logic mode_changed;
    logic low_battery;
    logic critical_battery;
    logic rc_lost;
    logic altitude;
    logic gps_bad;
    logic sensor_fault;
    logic fence_hit;
    logic at_home;
    logic touchdown;
  } flags_t;

endpackage

`default_nettype wire

>>> sv/fsms_debounce.sv
// Saturating debounce counter with its alarm decode.
// Standalone; used six times by the supervisor top level.
`timescale 1ns / 1ps
`default_nettype none

module fsms_debounce #(
  parameter int CNT_W = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             active,
  input  wire logic [CNT_W-1:0] thr,
  output logic                  alarm
);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  always_comb begin
    if (!active) begin
      cnt_nxt = '0;
    end else if (cnt_r < thr) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  // alarm reflects the count after this sample
  assign alarm = (cnt_nxt >= thr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (en) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/failsafe_mode_supervisor_core.sv
// Failsafe mode supervisor: one monitoring sample in, one mode decision out.
// A sample is registered in the input register on acceptance and evaluated
// from it once the output register is empty or being drained; the result
// lands in the output register, and a new sample is taken every cycle while
// results drain. The mode and debounce counters update in the same cycle as
// the result is registered, which is what sets the one-sample-per-cycle rate.
// Configuration writes go through the cfg_ channel (always ready) and should
// only be issued while no sample is in flight. Depends on fsms_pkg and
// fsms_debounce.
`timescale 1ns / 1ps
`default_nettype none

module failsafe_mode_supervisor_core #(
  parameter int DEBOUNCE_MAX = 15,
  parameter int RC_RUN_MAX   = 255
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,

  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire fsms_pkg::cfg_idx_t         cfg_index,
  input  wire logic [fsms_pkg::CFG_DATA_W-1:0] cfg_data,

  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [9:0]                 in_battery_level,
  input  wire logic [19:0]                in_altitude,
  input  wire logic [23:0]                in_home_distance,
  input  wire logic                       in_rc_present,
  input  wire logic                       in_gps_valid,
  input  wire logic                       in_sensors_healthy,

  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [2:0]                      out_flight_mode,
  output logic                            out_mode_changed,
  output logic                            out_low_battery_alarm,
  output logic                            out_critical_battery_alarm,
  output logic                            out_rc_lost_alarm,
  output logic                            out_altitude_alarm,
  output logic                            out_gps_lost_alarm,
  output logic                            out_sensor_fault_alarm,
  output logic                            out_fence_breach,
  output logic                            out_home_reached,
  output logic                            out_touchdown
);

  import fsms_pkg::*;

  localparam int DB_W  = $clog2(DEBOUNCE_MAX + 1);
  localparam int RUN_W = $clog2(RC_RUN_MAX + 1);
  localparam int THR_W = (DB_W > 4) ? DB_W : 4;
  localparam int TMO_W = (RUN_W > 8) ? RUN_W : 8;

  // ---------------- configuration registers ----------------
  logic [9:0]  batt_warn_r;
  logic [9:0]  batt_crit_r;
  logic [19:0] alt_limit_r;
  logic [23:0] fence_rad_r;
  logic [15:0] home_rad_r;
  logic [15:0] landed_alt_r;
  logic [7:0]  rc_timeout_r;
  logic [3:0]  debounce_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batt_warn_r  <= 10'd200;
      batt_crit_r  <= 10'd100;
      alt_limit_r  <= 20'd12000;
      fence_rad_r  <= 24'd50000;
      home_rad_r   <= 16'd200;
      landed_alt_r <= 16'd50;
      rc_timeout_r <= 8'd3;
      debounce_r   <= 4'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BATT_WARN:  batt_warn_r  <= cfg_data[9:0];
        CFG_BATT_CRIT:  batt_crit_r  <= cfg_data[9:0];
        CFG_ALT_LIMIT:  alt_limit_r  <= cfg_data[19:0];
        CFG_FENCE_RAD:  fence_rad_r  <= cfg_data[23:0];
        CFG_HOME_RAD:   home_rad_r   <= cfg_data[15:0];
        CFG_LANDED_ALT: landed_alt_r <= cfg_data[15:0];
        CFG_RC_TIMEOUT: rc_timeout_r <= cfg_data[7:0];
        CFG_DEBOUNCE:   debounce_r   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  logic s_valid_r;
  logic out_valid_r;
  logic advance;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s_valid_r || advance;
  assign out_valid = out_valid_r;

  wire logic step = s_valid_r && advance;

  // ---------------- input register ----------------
  logic [9:0]  batt_r;
  logic [19:0] alt_r;
  logic [23:0] dist_r;
  logic        rc_ok_r;
  logic        gps_ok_r;
  logic        sens_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ready) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      batt_r    <= in_battery_level;
      alt_r     <= in_altitude;
      dist_r    <= in_home_distance;
      rc_ok_r   <= in_rc_present;
      gps_ok_r  <= in_gps_valid;
      sens_ok_r <= in_sensors_healthy;
    end
  end

  // ---------------- thresholds ----------------
  logic [THR_W-1:0] thr_ext;
  logic [DB_W-1:0]  thr;
  logic [TMO_W-1:0] tmo;

  always_comb begin
    thr_ext = (debounce_r == 4'd0) ? THR_W'(1) : THR_W'(debounce_r);
    if (thr_ext > THR_W'(DEBOUNCE_MAX)) begin
      thr_ext = THR_W'(DEBOUNCE_MAX);
    end
    thr = thr_ext[DB_W-1:0];
    tmo = (rc_timeout_r == 8'd0) ? TMO_W'(1) : TMO_W'(rc_timeout_r);
  end

  // ---------------- RC loss run ----------------
  logic [RUN_W-1:0] run_r;
  logic [RUN_W-1:0] run_nxt;

  always_comb begin
    if (rc_ok_r) begin
      run_nxt = '0;
    end else if (run_r < RUN_W'(RC_RUN_MAX)) begin
      run_nxt = run_r + RUN_W'(1);
    end else begin
      run_nxt = run_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (step) begin
      run_r <= run_nxt;
    end
  end

  // ---------------- debounced alarms ----------------
  logic warn, crit, rcl, alth, gpsl, sensb;

  fsms_debounce #(.CNT_W(DB_W)) u_db_warn (
    .clk(clk), .rst_n(rst_n), .en(step),
    .active(batt_r < batt_warn_r), .thr(thr), .alarm(warn)
  );
  fsms_debounce #(.CNT_W(DB_W)) u_db_crit (
    .clk(clk), .rst_n(rst_n), .en(step),
    .active(batt_r < batt_crit_r), .thr(thr), .alarm(crit)
  );
  fsms_debounce #(.CNT_W(DB_W)) u_db_rc (
    .clk(clk), .rst_n(rst_n), .en(step),
    .active(TMO_W'(run_nxt) >= tmo), .thr(thr), .alarm(rcl)
  );
  fsms_debounce #(.CNT_W(DB_W)) u_db_alt (
    .clk(clk), .rst_n(rst_n), .en(step),
    .active(alt_r > alt_limit_r), .thr(thr), .alarm(alth)
  );
  fsms_debounce #(.CNT_W(DB_W)) u_db_gps (
    .clk(clk), .rst_n(rst_n), .en(step),
    .active(!gps_ok_r), .thr(thr), .alarm(gpsl)
  );
  fsms_debounce #(.CNT_W(DB_W)) u_db_sens (
    .clk(clk), .rst_n(rst_n), .en(step),
    .active(!sens_ok_r), .thr(thr), .alarm(sensb)
  );

  // ---------------- mode decision ----------------
  mode_t mode_r;
  mode_t mode_nxt;
  logic  fence;
  logic  home;
  logic  touch;

  assign fence = (dist_r > fence_rad_r);
  assign home  = (mode_r == MODE_RTH) && (dist_r <= 24'(home_rad_r));

  always_comb begin
    priority if (sensb) begin
      mode_nxt = MODE_EMERGENCY;
    end else if (mode_r == MODE_EMERGENCY) begin
      mode_nxt = MODE_EMERGENCY;
    end else if (mode_r == MODE_LAND) begin
      mode_nxt = MODE_LAND;        // land is latched; only a sensor fault leaves it
    end else if (crit) begin
      mode_nxt = MODE_LAND;
    end else if (mode_r == MODE_RTH) begin
      mode_nxt = home ? MODE_LAND : MODE_RTH;
    end else if (rcl || fence || gpsl) begin
      mode_nxt = MODE_RTH;
    end else if (alth || warn) begin
      mode_nxt = MODE_WARNING;
    end else begin
      mode_nxt = MODE_NORMAL;
    end
  end

  assign touch = (mode_nxt == MODE_LAND) && (alt_r <= 20'(landed_alt_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
    end else if (step) begin
      mode_r <= mode_nxt;
    end
  end

  // ---------------- result register ----------------
  mode_t  res_mode_r;
  flags_t res_flags_r;
  flags_t flags_nxt;

  always_comb begin
    flags_nxt.mode_changed     = (mode_nxt != mode_r);
    flags_nxt.low_battery      = warn;
    flags_nxt.critical_battery = crit;
    flags_nxt.rc_lost          = rcl;
    flags_nxt.altitude         = alth;
    flags_nxt.gps_bad          = gpsl;
    flags_nxt.sensor_fault     = sensb;
    flags_nxt.fence_hit        = fence;
    flags_nxt.at_home          = home;
    flags_nxt.touchdown        = touch;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_mode_r  <= mode_nxt;
      res_flags_r <= flags_nxt;
    end
  end

  assign out_flight_mode            = res_mode_r;
  assign out_mode_changed           = res_flags_r.mode_changed;
  assign out_low_battery_alarm      = res_flags_r.low_battery;
  assign out_critical_battery_alarm = res_flags_r.critical_battery;
  assign out_rc_lost_alarm          = res_flags_r.rc_lost;
  assign out_altitude_alarm         = res_flags_r.altitude;
  assign out_gps_lost_alarm         = res_flags_r.gps_bad;
  assign out_sensor_fault_alarm     = res_flags_r.sensor_fault;
  assign out_fence_breach           = res_flags_r.fence_hit;
  assign out_home_reached           = res_flags_r.at_home;
  assign out_touchdown              = res_flags_r.touchdown;

endmodule

`default_nettype wire
